[hdl/ptal_pkg.sv]
package ptal_pkg;

   localparam int MAC_W = 48;
   localparam int TIME_W = 32;
   localparam int EV_W = 3;
   localparam int PC_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam int DEFAULT_PEER_SLOTS = 8;
   localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT_MS = 32'd30000;

   localparam logic MODE_ANNOUNCE = 1'b0;
   localparam logic MODE_SWEEP = 1'b1;

   // Register index as decoded from csr_paddr[3].
   localparam logic REG_SELF_MAC = 1'b0;
   localparam logic REG_TIMEOUT_MS = 1'b1;

   typedef enum logic [EV_W-1:0] {
      EV_REFRESHED = 3'd0,
      EV_DISCOVERED = 3'd1,
      EV_DROPPED_FULL = 3'd2,
      EV_SELF_IGNORED = 3'd3,
      EV_LOST = 3'd4,
      EV_SWEEP_DONE = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DECIDE,
      ST_ELECT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [TIME_W-1:0] seen_time;
   } entry_type;

   typedef struct packed {
      logic [MAC_W-1:0] self_mac;
      logic [TIME_W-1:0] timeout_ms;
   } cfg_type;

endpackage

[hdl/ptal_ifs.sv]
interface ptal_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [ptal_pkg::TIME_W-1:0] now_ms;
   logic [ptal_pkg::MAC_W-1:0] peer_mac;

   modport source (output valid, mode, now_ms, peer_mac, input ready);
   modport sink (input valid, mode, now_ms, peer_mac, output ready);
endinterface

interface ptal_rsp_if;
   logic valid;
   logic ready;
   logic [ptal_pkg::EV_W-1:0] event_res;
   logic [ptal_pkg::MAC_W-1:0] event_mac;
   logic is_leader;
   logic role_changed;
   logic [ptal_pkg::PC_W-1:0] peer_count;
   logic last;

   modport source (output valid, event_res, event_mac, is_leader, role_changed,
                   peer_count, last, input ready);
   modport sink (input valid, event_res, event_mac, is_leader, role_changed,
                 peer_count, last, output ready);
endinterface

[hdl/ptal_csr.sv]
module ptal_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ptal_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ptal_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ptal_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output ptal_pkg::cfg_type cfg
);
   import ptal_pkg::*;

   logic [MAC_W-1:0] self_mac_ff, self_mac_in;
   logic [TIME_W-1:0] timeout_ff, timeout_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      self_mac_in = self_mac_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         unique case (csr_paddr[3])
            REG_SELF_MAC: self_mac_in = csr_pwdata[MAC_W-1:0];
            REG_TIMEOUT_MS: timeout_in = csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_mac_ff <= '0;
         timeout_ff <= DEFAULT_TIMEOUT_MS;
      end else begin
         self_mac_ff <= self_mac_in;
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_SELF_MAC: csr_prdata = CSR_DATA_W'(self_mac_ff);
         REG_TIMEOUT_MS: csr_prdata = CSR_DATA_W'(timeout_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.self_mac = self_mac_ff;
   assign cfg.timeout_ms = timeout_ff;

endmodule

[hdl/ptal_table_mem.sv]
module ptal_table_mem #(
   parameter int DEPTH = ptal_pkg::DEFAULT_PEER_SLOTS - 1,
   parameter int AW = 3
) (
   input  logic clock,
   input  logic [AW-1:0] rd_addr,
   output ptal_pkg::entry_type rd_data,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  ptal_pkg::entry_type wr_data
);
   import ptal_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ptal_ctrl.sv]
module ptal_ctrl #(
   parameter int PEER_SLOTS = ptal_pkg::DEFAULT_PEER_SLOTS,
   parameter int AW = 3,
   parameter int CW = 3
) (
   input  logic clock,
   input  logic reset,
   input  ptal_pkg::cfg_type cfg,
   ptal_req_if.sink req_bus,
   ptal_rsp_if.source rsp_bus,
   output logic [AW-1:0] mem_rd_addr,
   input  ptal_pkg::entry_type mem_rd_data,
   output logic mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output ptal_pkg::entry_type mem_wr_data
);
   import ptal_pkg::*;

   localparam int DEPTH = PEER_SLOTS - 1;
   localparam int XW = (CW > PC_W) ? CW : PC_W;

   function automatic logic [PC_W-1:0] peer_count_of(input logic [CW-1:0] c);
      logic [XW-1:0] e;
      e = XW'(c) + XW'(1);
      return e[PC_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic mode_ff, mode_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] bound_ff, bound_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic lower_ff, lower_in;
   logic removed_ff, removed_in;
   logic leader_ff, leader_in;
   logic changed_ff, changed_in;
   event_type ev_ff, ev_in;
   logic [MAC_W-1:0] emac_ff, emac_in;

   logic o_valid_ff, o_valid_in;
   event_type o_ev_ff, o_ev_in;
   logic [MAC_W-1:0] o_mac_ff, o_mac_in;
   logic o_lead_ff, o_lead_in;
   logic o_chg_ff, o_chg_in;
   logic [PC_W-1:0] o_pc_ff, o_pc_in;
   logic o_last_ff, o_last_in;

   logic slot_free;
   logic last_entry;
   logic stale;
   logic entry_lower;
   logic new_lead;
   logic [AW-1:0] next_idx;
   logic [TIME_W-1:0] age;

   assign slot_free = !o_valid_ff || rsp_bus.ready;
   assign last_entry = (CW'(rd_idx_ff) + CW'(1)) == bound_ff;
   assign next_idx = rd_idx_ff + AW'(1);
   assign age = now_ff - mem_rd_data.seen_time;
   assign stale = age > cfg.timeout_ms;
   assign entry_lower = mem_rd_data.mac < cfg.self_mac;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      now_in = now_ff;
      mac_in = mac_ff;
      count_in = count_ff;
      bound_in = bound_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      lower_in = lower_ff;
      removed_in = removed_ff;
      leader_in = leader_ff;
      changed_in = changed_ff;
      ev_in = ev_ff;
      emac_in = emac_ff;
      new_lead = 1'b1;

      o_valid_in = o_valid_ff & ~rsp_bus.ready;
      o_ev_in = o_ev_ff;
      o_mac_in = o_mac_ff;
      o_lead_in = o_lead_ff;
      o_chg_in = o_chg_ff;
      o_pc_in = o_pc_ff;
      o_last_in = o_last_ff;

      req_bus.ready = 1'b0;
      mem_rd_addr = rd_idx_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = wr_idx_ff;
      mem_wr_data = mem_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            mem_rd_addr = '0;
            if (req_bus.valid) begin
               mode_in = req_bus.mode;
               now_in = req_bus.now_ms;
               mac_in = req_bus.peer_mac;
               bound_in = count_ff;
               rd_idx_in = '0;
               wr_idx_in = '0;
               lower_in = 1'b0;
               removed_in = 1'b0;
               changed_in = 1'b0;
               if (req_bus.mode == MODE_ANNOUNCE && req_bus.peer_mac == cfg.self_mac) begin
                  ev_in = EV_SELF_IGNORED;
                  emac_in = req_bus.peer_mac;
                  state_in = ST_FINISH;
               end else if (count_ff == '0) begin
                  state_in = (req_bus.mode == MODE_ANNOUNCE) ? ST_DECIDE : ST_ELECT;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (mode_ff == MODE_ANNOUNCE) begin
               if (mem_rd_data.mac == mac_ff) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = rd_idx_ff;
                  mem_wr_data.mac = mem_rd_data.mac;
                  mem_wr_data.seen_time = now_ff;
                  ev_in = EV_REFRESHED;
                  emac_in = mac_ff;
                  state_in = ST_FINISH;
               end else begin
                  lower_in = lower_ff | entry_lower;
                  if (last_entry) begin
                     state_in = ST_DECIDE;
                  end else begin
                     rd_idx_in = next_idx;
                     mem_rd_addr = next_idx;
                  end
               end
            end else if (stale && !slot_free) begin
               // Read the same entry again so its data is still there next cycle.
               mem_rd_addr = rd_idx_ff;
            end else begin
               if (stale) begin
                  o_valid_in = 1'b1;
                  o_ev_in = EV_LOST;
                  o_mac_in = mem_rd_data.mac;
                  o_lead_in = leader_ff;
                  o_chg_in = 1'b0;
                  o_pc_in = peer_count_of(count_ff - CW'(1));
                  o_last_in = 1'b0;
                  count_in = count_ff - CW'(1);
                  removed_in = 1'b1;
               end else begin
                  // Kept entries close up toward the front of the table.
                  mem_wr_en = (wr_idx_ff != rd_idx_ff);
                  mem_wr_addr = wr_idx_ff;
                  wr_idx_in = wr_idx_ff + AW'(1);
                  lower_in = lower_ff | entry_lower;
               end
               if (last_entry) begin
                  state_in = ST_ELECT;
               end else begin
                  rd_idx_in = next_idx;
                  mem_rd_addr = next_idx;
               end
            end
         end

         ST_DECIDE: begin
            emac_in = mac_ff;
            if (count_ff >= CW'(DEPTH)) begin
               ev_in = EV_DROPPED_FULL;
               changed_in = 1'b0;
            end else begin
               mem_wr_en = 1'b1;
               mem_wr_addr = count_ff[AW-1:0];
               mem_wr_data.mac = mac_ff;
               mem_wr_data.seen_time = now_ff;
               count_in = count_ff + CW'(1);
               new_lead = !(lower_ff || (mac_ff < cfg.self_mac));
               changed_in = new_lead != leader_ff;
               leader_in = new_lead;
               ev_in = EV_DISCOVERED;
            end
            state_in = ST_FINISH;
         end

         ST_ELECT: begin
            if (removed_ff) begin
               new_lead = !lower_ff;
               changed_in = new_lead != leader_ff;
               leader_in = new_lead;
            end else begin
               changed_in = 1'b0;
            end
            ev_in = EV_SWEEP_DONE;
            emac_in = '0;
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (slot_free) begin
               o_valid_in = 1'b1;
               o_ev_in = ev_ff;
               o_mac_in = emac_ff;
               o_lead_in = leader_ff;
               o_chg_in = changed_ff;
               o_pc_in = peer_count_of(count_ff);
               o_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         leader_ff <= 1'b1;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         leader_ff <= leader_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      now_ff <= now_in;
      mac_ff <= mac_in;
      bound_ff <= bound_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      lower_ff <= lower_in;
      removed_ff <= removed_in;
      changed_ff <= changed_in;
      ev_ff <= ev_in;
      emac_ff <= emac_in;
      o_ev_ff <= o_ev_in;
      o_mac_ff <= o_mac_in;
      o_lead_ff <= o_lead_in;
      o_chg_ff <= o_chg_in;
      o_pc_ff <= o_pc_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_bus.valid = o_valid_ff;
   assign rsp_bus.event_res = o_ev_ff;
   assign rsp_bus.event_mac = o_mac_ff;
   assign rsp_bus.is_leader = o_lead_ff;
   assign rsp_bus.role_changed = o_chg_ff;
   assign rsp_bus.peer_count = o_pc_ff;
   assign rsp_bus.last = o_last_ff;

endmodule

[hdl/peer_table_aging_leader_election_unit.sv]
// Peer table with aging and lowest-MAC leader election. The block holds up to
// PEER_SLOTS-1 other peers in a single-port-read, single-port-write table and
// takes one item at a time. An announce walks the table one entry per cycle
// through the memory read port up to a matching entry, which it refreshes;
// when no entry matches it goes on to a decision step that adds the peer, or
// drops it when the table is full. A sweep walks every stored entry. Both can
// be held while the result channel does not take a held transfer (a lost
// transfer, or the final one). Each item ends with one transfer that has last
// set. The table needs no clearing after reset; only entries below the stored
// count are ever used.
// Registers: self_mac at byte address 0 and timeout_ms (reset 30000) at byte
// address 8, both 64-bit APB words.
module peer_table_aging_leader_election_unit #(
   parameter int PEER_SLOTS = ptal_pkg::DEFAULT_PEER_SLOTS
) (
   input  logic clock,
   input  logic reset,
   ptal_req_if.sink req_bus,
   ptal_rsp_if.source rsp_bus,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ptal_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ptal_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ptal_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import ptal_pkg::*;

   localparam int DEPTH = PEER_SLOTS - 1;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(PEER_SLOTS);

   cfg_type cfg;
   logic [AW-1:0] mem_rd_addr;
   entry_type mem_rd_data;
   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type mem_wr_data;

   ptal_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   ptal_table_mem #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_table (
      .clock(clock),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   ptal_ctrl #(
      .PEER_SLOTS(PEER_SLOTS),
      .AW(AW),
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data)
   );

endmodule
